[sv/mutl_pkg.sv]
`default_nettype none
package mutl_pkg;

  localparam int LUT_COUNT       = 16;
  localparam int WORD_COUNT      = 8;
  localparam int NIB_W           = 4;
  localparam int CMD_W           = 2;
  localparam int UNIT_W          = 6;
  localparam int ID_W            = 64;
  localparam int SEL_W           = 32;
  localparam int WORD_W          = 32;
  localparam int CFG_DATA_W      = 32;
  localparam int REG_W           = 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W          = $clog2(2 * WORD_COUNT);
  localparam int WIDX_W          = $clog2(WORD_COUNT);
  localparam int NUM_UNITS_RESET = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENABLE  = 2'd0,
    CMD_DISABLE = 2'd1
  } cmd_e;

  typedef enum logic [REG_W-1:0] {
    REG_NUM_UNITS     = 1'b0,
    REG_CLEAR_PATTERN = 1'b1
  } reg_e;

  typedef struct packed {
    logic             err;
    logic             enable;
    logic [SEL_W-1:0] sel;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  mask;
  } job_t;

  function automatic logic [WORD_W-1:0] truth_word(input logic [ID_W-1:0]   id,
                                                   input logic [ID_W-1:0]   mask,
                                                   input logic [WIDX_W-1:0] w);
    logic [WORD_W-1:0] word;
    logic [NIB_W-1:0]  nib;
    logic [NIB_W-1:0]  cm;
    logic [NIB_W-1:0]  lo;
    logic [NIB_W-1:0]  hi;
    word = '0;
    lo   = NIB_W'({w, 1'b0});
    hi   = NIB_W'({w, 1'b1});
    for (int k = 0; k < LUT_COUNT; k++) begin
      nib             = id[NIB_W*k +: NIB_W];
      cm              = mask[NIB_W*k +: NIB_W];
      word[2*k]       = (nib & cm) == (lo & cm);
      word[2*k + 1]   = (nib & cm) == (hi & cm);
    end
    return word;
  endfunction

endpackage
`default_nettype wire

[sv/mutl_if.sv]
`default_nettype none
interface mutl_req_if;
  import mutl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [UNIT_W-1:0] unit;
  logic [ID_W-1:0]   match_id;
  logic [ID_W-1:0]   match_mask;
  modport source(output valid, command, unit, match_id, match_mask, input ready);
  modport sink(input valid, command, unit, match_id, match_mask, output ready);
endinterface

interface mutl_res_if;
  import mutl_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEL_W-1:0]  select_mask;
  logic [WORD_W-1:0] data_word;
  logic              load_last;
  logic              error;
  logic              last;
  modport source(output valid, select_mask, data_word, load_last, error, last, input ready);
  modport sink(input valid, select_mask, data_word, load_last, error, last, output ready);
endinterface

interface mutl_cfg_if;
  import mutl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_W-1:0]      index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/mutl_front.sv]
`default_nettype none
module mutl_front (
  input  logic [mutl_pkg::CMD_W-1:0]  command_i,
  input  logic [mutl_pkg::UNIT_W-1:0] unit_i,
  input  logic [mutl_pkg::ID_W-1:0]   match_id_i,
  input  logic [mutl_pkg::ID_W-1:0]   match_mask_i,
  input  logic [mutl_pkg::UNIT_W-1:0] num_units_i,
  output mutl_pkg::job_t              job_o
);
  import mutl_pkg::*;

  logic bad_cmd;
  logic bad_unit;

  assign bad_cmd  = (command_i != CMD_ENABLE) && (command_i != CMD_DISABLE);
  assign bad_unit = unit_i >= num_units_i;

  always_comb begin
    job_o.err    = bad_cmd || bad_unit;
    job_o.enable = command_i == CMD_ENABLE;
    job_o.sel    = '0;
    if (unit_i < UNIT_W'(SEL_W)) begin
      job_o.sel = SEL_W'(1) << unit_i;
    end
    job_o.id     = match_id_i;
    job_o.mask   = match_mask_i;
  end

endmodule
`default_nettype wire

[sv/mutl_queue.sv]
`default_nettype none
module mutl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mutl_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output mutl_pkg::job_t head_job_o
);
  import mutl_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = count_q == QCNT_W'(QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

[sv/mutl_back.sv]
`default_nettype none
module mutl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  mutl_pkg::job_t                job_i,
  output logic                          job_pop_o,
  input  logic [mutl_pkg::WORD_W-1:0]   clear_pattern_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [mutl_pkg::SEL_W-1:0]    select_mask_o,
  output logic [mutl_pkg::WORD_W-1:0]   data_word_o,
  output logic                          load_last_o,
  output logic                          error_o,
  output logic                          last_o
);
  import mutl_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              valid_q, valid_d;
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              load_last_q, load_last_d;
  logic              error_q, error_d;
  logic              last_q, last_d;
  logic              load;
  logic              in_clear;
  logic              fin;
  logic [WIDX_W-1:0] widx;

  assign load     = job_valid_i && (!valid_q || res_ready_i);
  assign in_clear = step_q < STEP_W'(WORD_COUNT);
  assign widx     = WIDX_W'(STEP_W'(2 * WORD_COUNT - 1) - step_q);

  always_comb begin
    priority if (job_i.err) begin
      fin = 1'b1;
    end else if (!job_i.enable) begin
      fin = step_q == STEP_W'(WORD_COUNT - 1);
    end else begin
      fin = step_q == STEP_W'(2 * WORD_COUNT - 1);
    end
  end

  always_comb begin
    step_d      = step_q;
    valid_d     = valid_q;
    sel_d       = sel_q;
    word_d      = word_q;
    load_last_d = load_last_q;
    error_d     = error_q;
    last_d      = last_q;
    if (valid_q && res_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      step_d  = fin ? '0 : step_q + STEP_W'(1);
      last_d  = fin;
      if (job_i.err) begin
        sel_d       = '0;
        word_d      = '0;
        load_last_d = 1'b0;
        error_d     = 1'b1;
      end else begin
        sel_d       = job_i.sel;
        error_d     = 1'b0;
        if (in_clear) begin
          word_d      = clear_pattern_i;
          load_last_d = step_q == STEP_W'(WORD_COUNT - 1);
        end else begin
          word_d      = truth_word(job_i.id, job_i.mask, widx);
          load_last_d = step_q == STEP_W'(2 * WORD_COUNT - 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    word_q      <= word_d;
    load_last_q <= load_last_d;
    error_q     <= error_d;
    last_q      <= last_d;
  end

  assign job_pop_o     = load && fin;
  assign res_valid_o   = valid_q;
  assign select_mask_o = sel_q;
  assign data_word_o   = word_q;
  assign load_last_o   = load_last_q;
  assign error_o       = error_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

[sv/match_unit_truth_table_loader.sv]
// match unit truth table loader
//
// req_i carries one request per transaction: command, unit, match_id and
// match_mask. res_o returns the word sequence for that request, one word
// per transaction, with last set on the final word of the request.
// cfg_i writes num_units (index 0) and clear_pattern (index 1); it is
// always ready and should only be written while no request is in flight.
//
// a rejected request gives a single error result; disable gives eight
// clearing words; enable gives eight clearing words then eight truth words.
// so a request occupies the output for 1, 8 or 16 words, one word per
// cycle from the sequencer in the back end while res_o does not stall. the
// first word of a request passes through the queue and then the output register.
// a two-entry queue sits between the request decode and the sequencer, so
// new requests are taken while earlier ones are still being emitted.
// when res_o stalls, the output register holds its word and the sequencer
// waits; once the queue fills, req_i drops ready.
// reset empties the queue and output register and restores num_units to
// 32 and clear_pattern to 0.
`default_nettype none
module match_unit_truth_table_loader (
  input logic       clk_i,
  input logic       rst_ni,
  mutl_req_if.sink  req_i,
  mutl_res_if.source res_o,
  mutl_cfg_if.sink  cfg_i
);
  import mutl_pkg::*;

  logic [UNIT_W-1:0] num_units_q;
  logic [WORD_W-1:0] clear_pattern_q;
  job_t              front_job;
  job_t              head_job;
  logic              queue_full;
  logic              head_valid;
  logic              head_pop;
  logic              push;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_units_q     <= UNIT_W'(NUM_UNITS_RESET);
      clear_pattern_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_NUM_UNITS: begin
          num_units_q <= cfg_i.data[UNIT_W-1:0];
        end
        REG_CLEAR_PATTERN: begin
          clear_pattern_q <= cfg_i.data[WORD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mutl_front u_front (
    .command_i    (req_i.command),
    .unit_i       (req_i.unit),
    .match_id_i   (req_i.match_id),
    .match_mask_i (req_i.match_mask),
    .num_units_i  (num_units_q),
    .job_o        (front_job)
  );

  assign req_i.ready = !queue_full;
  assign push        = req_i.valid && !queue_full;

  mutl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (front_job),
    .full_o       (queue_full),
    .pop_i        (head_pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  mutl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .job_pop_o       (head_pop),
    .clear_pattern_i (clear_pattern_q),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .select_mask_o   (res_o.select_mask),
    .data_word_o     (res_o.data_word),
    .load_last_o     (res_o.load_last),
    .error_o         (res_o.error),
    .last_o          (res_o.last)
  );

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.error |-> res_o.last && !res_o.load_last && res_o.select_mask == '0)
    else $error("error result malformed");

  a_last_completes_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last && !res_o.error |-> res_o.load_last)
    else $error("request ended without completing a load");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("queue popped while empty");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.error |-> $onehot0(res_o.select_mask))
    else $error("unit selection not one-hot");

endmodule
`default_nettype wire

[tb/sv/load_sequence_checker.sv]
`default_nettype none
module load_sequence_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  mutl_req_if        req,
  mutl_res_if        res,
  mutl_cfg_if        cfg,
  output int         fail_count_o,
  output int         pending_o
);
  import mutl_pkg::*;

  typedef struct packed {
    logic [SEL_W-1:0]  select_mask;
    logic [WORD_W-1:0] data_word;
    logic              load_last;
    logic              error;
    logic              last;
  } load_word_t;

  load_word_t            expected_words[$];
  logic [UNIT_W-1:0]     unit_count;
  logic [CFG_DATA_W-1:0] clear_word;

  // lut k, bit b of word w is set when the cared bits of nibble k equal those of 2w+b
  function automatic logic [WORD_W-1:0] lut_word(logic [ID_W-1:0] id, logic [ID_W-1:0] mask,
                                                 int unsigned w);
    logic [WORD_W-1:0] word;
    logic [NIB_W-1:0]  nib;
    logic [NIB_W-1:0]  care;
    logic [NIB_W-1:0]  code;
    word = '0;
    for (int k = 0; k < LUT_COUNT; k++) begin
      nib  = id[NIB_W*k +: NIB_W];
      care = mask[NIB_W*k +: NIB_W];
      for (int b = 0; b < 2; b++) begin
        code = NIB_W'(2 * w + b);
        word[2*k + b] = ((nib ^ code) & care) == '0;
      end
    end
    return word;
  endfunction

  task automatic predict_load_sequence(logic [CMD_W-1:0] command, logic [UNIT_W-1:0] unit,
                                       logic [ID_W-1:0] id, logic [ID_W-1:0] mask);
    load_word_t       item;
    logic [SEL_W-1:0] sel;
    logic             loads;
    if (unit >= unit_count || (command != CMD_ENABLE && command != CMD_DISABLE)) begin
      item = '{select_mask: '0, data_word: '0, load_last: 1'b0, error: 1'b1, last: 1'b1};
      expected_words.push_back(item);
    end else begin
      loads = (command == CMD_ENABLE);
      sel   = (unit < SEL_W) ? (SEL_W'(1) << unit) : '0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        item = '{select_mask: sel, data_word: clear_word, load_last: i == WORD_COUNT - 1,
                 error: 1'b0, last: (i == WORD_COUNT - 1) && !loads};
        expected_words.push_back(item);
      end
      if (loads) begin
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
          item = '{select_mask: sel, data_word: lut_word(id, mask, i), load_last: i == 0,
                   error: 1'b0, last: i == 0};
          expected_words.push_back(item);
        end
      end
    end
  endtask

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $error("%s: expected %h, actual %h", name, want, got);
    return 1;
  endfunction

  task automatic check_word();
    load_word_t want;
    if (expected_words.size() == 0) begin
      fail_count_o++;
      $error("unexpected result transaction: select_mask %h data_word %h error %b",
             res.select_mask, res.data_word, res.error);
    end else begin
      want = expected_words.pop_front();
      fail_count_o += field_mismatch("select_mask", want.select_mask, res.select_mask);
      fail_count_o += field_mismatch("data_word", want.data_word, res.data_word);
      fail_count_o += field_mismatch("load_last", 32'(want.load_last), 32'(res.load_last));
      fail_count_o += field_mismatch("error", 32'(want.error), 32'(res.error));
      fail_count_o += field_mismatch("last", 32'(want.last), 32'(res.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_count = UNIT_W'(NUM_UNITS_RESET);
      clear_word = '0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_NUM_UNITS) begin
          unit_count = cfg.data[UNIT_W-1:0];
        end else begin
          clear_word = cfg.data;
        end
      end
      if (res.valid && res.ready) check_word();
      if (req.valid && req.ready) begin
        predict_load_sequence(req.command, req.unit, req.match_id, req.match_mask);
      end
      pending_o <= expected_words.size();
    end
  end

endmodule
`default_nettype wire

[tb/sv/match_unit_truth_table_loader_test.sv]
`default_nettype none
module match_unit_truth_table_loader_test;
  import mutl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_INVALID  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic long_hold = 1'b0;
  logic calm = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet;
  int   cur_units;

  mutl_req_if req();
  mutl_res_if res();
  mutl_cfg_if cfg();

  match_unit_truth_table_loader dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  load_sequence_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .res          (res),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    res.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold) begin
        long_hold <= 1'b0;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_request(logic [CMD_W-1:0] command, logic [UNIT_W-1:0] unit,
                              logic [ID_W-1:0] id, logic [ID_W-1:0] mask, bit gaps);
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.command    <= command;
    req.unit       <= unit;
    req.match_id   <= id;
    req.match_mask <= mask;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic random_request(bit gaps);
    logic [CMD_W-1:0]  command;
    logic [UNIT_W-1:0] unit;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   mask;
    int                pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) command = CMD_ENABLE;
    else if (pick < 17) command = CMD_DISABLE;
    else if (pick < 19) command = CMD_INVALID;
    else command = CMD_RESERVED;
    if (cur_units != 0 && $urandom_range(0, 7) != 0) begin
      unit = UNIT_W'($urandom_range(0, cur_units - 1));
    end else begin
      unit = UNIT_W'($urandom_range(0, 63));
    end
    id = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: mask = '1;
      1: mask = '0;
      2: mask = {$urandom, $urandom};
      default: begin
        for (int k = 0; k < LUT_COUNT; k++) begin
          case ($urandom_range(0, 2))
            0: mask[NIB_W*k +: NIB_W] = '0;
            1: mask[NIB_W*k +: NIB_W] = '1;
            default: mask[NIB_W*k +: NIB_W] = NIB_W'($urandom_range(0, 15));
          endcase
        end
      end
    endcase
    send_request(command, unit, id, mask, gaps);
  endtask

  // sender stops until every expected word has come back
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_registers(int units, logic [CFG_DATA_W-1:0] pattern);
    logic [CFG_DATA_W-1:0] units_word;
    units_word = $urandom;
    units_word[UNIT_W-1:0] = UNIT_W'(units);
    cfg.valid <= 1'b1;
    cfg.index <= REG_NUM_UNITS;
    cfg.data  <= units_word;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.index <= REG_CLEAR_PATTERN;
    cfg.data  <= pattern;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_units = units;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    req.valid      <= 1'b0;
    req.command    <= CMD_ENABLE;
    req.unit       <= '0;
    req.match_id   <= '0;
    req.match_mask <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= REG_NUM_UNITS;
    cfg.data       <= '0;
    cur_units = NUM_UNITS_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: 32 units, clearing word 0
    send_request(CMD_ENABLE, 0, '0, '1, 1'b1);
    send_request(CMD_ENABLE, 31, '1, '1, 1'b1);
    send_request(CMD_DISABLE, 0, '1, '1, 1'b1);
    send_request(CMD_DISABLE, 31, '0, '0, 1'b1);
    send_request(CMD_ENABLE, 32, '1, '1, 1'b1);
    send_request(CMD_DISABLE, 63, '0, '1, 1'b1);
    send_request(CMD_INVALID, 0, '1, '1, 1'b1);
    send_request(CMD_RESERVED, 31, '0, '0, 1'b1);
    send_request(CMD_ENABLE, 5, '1, '0, 1'b1);
    send_request(CMD_ENABLE, 7, 64'h0123_4567_89AB_CDEF, '1, 1'b1);
    send_request(CMD_ENABLE, 16, 64'hFEDC_BA98_7654_3210, 64'h1111_1111_1111_1111, 1'b1);
    send_request(CMD_ENABLE, 30, 64'h8888_8888_8888_8888, 64'hEEEE_EEEE_EEEE_EEEE, 1'b1);
    send_request(CMD_ENABLE, 1, 64'hA5A5_A5A5_A5A5_A5A5, 64'hF0F0_F0F0_0F0F_0F0F, 1'b1);
    send_request(CMD_ENABLE, 9, 64'h7777_7777_7777_7777, 64'h8888_8888_8888_8888, 1'b1);

    // units past the selection width
    drain();
    program_registers(63, 32'hFFFF_FFFF);
    send_request(CMD_ENABLE, 32, 64'h1357_9BDF_0246_8ACE, '1, 1'b1);
    send_request(CMD_DISABLE, 62, '1, '1, 1'b1);
    send_request(CMD_ENABLE, 63, '1, '1, 1'b1);
    send_request(CMD_ENABLE, 40, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);

    // no units present
    drain();
    program_registers(0, 32'h0000_0000);
    send_request(CMD_DISABLE, 0, '0, '0, 1'b1);
    send_request(CMD_ENABLE, 0, '1, '1, 1'b1);

    drain();
    program_registers(32, 32'h0000_0000);
    repeat (60) random_request(1'b1);

    drain();
    program_registers(63, $urandom);
    repeat (80) random_request(1'b1);

    drain();
    program_registers(1, 32'h0000_0000);
    repeat (40) random_request(1'b1);

    drain();
    program_registers($urandom_range(2, 31), $urandom);
    repeat (80) random_request(1'b1);

    drain();
    program_registers(33, 32'hFFFF_FFFF);
    repeat (40) random_request(1'b1);

    drain();
    program_registers(32, $urandom);
    long_hold <= 1'b1;
    repeat (16) random_request(1'b0);
    repeat (34) random_request(1'b1);
    drain();
    repeat (20) random_request(1'b1);
    calm <= 1'b1;
    repeat (40) random_request(1'b1);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
